FILE: hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer-to-text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'h57;   // 'a' - 10
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

    typedef struct packed {
        logic                empty;
        logic                neg;
        logic [RADIX_W-1:0]  radix;
    } cmd_flags_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {2'b00, d};
        if (d < DEC_LIMIT)
        begin
            return ZERO_CHAR + ext;
        end
        else
        begin
            return ALPHA_BASE + ext;
        end
    endfunction

endpackage

FILE: hw/rtl/itoa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_front
// Holds the radix register, classifies each item and forms its magnitude.
// ----------------------------------------------------------------------------
module itoa_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [itoa_pkg::RADIX_W-1:0]      radix,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output itoa_pkg::cmd_flags_t              cmd_flags,
    output logic [VALUE_WIDTH-1:0]            cmd_mag
);

    logic [itoa_pkg::RADIX_W-1:0] radix_reg;
    logic [VALUE_WIDTH-1:0]       value_u;
    logic                         neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itoa_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= radix;
        end
    end

    assign cfg_ready = 1'b1;
    assign value_u   = value;
    assign neg       = value_u[VALUE_WIDTH-1];

    assign cmd_valid       = in_valid;
    assign in_ready        = cmd_ready;
    assign cmd_flags.empty = !(radix_reg inside {[itoa_pkg::RADIX_MIN:itoa_pkg::RADIX_MAX]});
    assign cmd_flags.neg   = neg;
    assign cmd_flags.radix = radix_reg;
    assign cmd_mag         = neg ? (~value_u + 1'b1) : value_u;

endmodule

FILE: hw/rtl/itoa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_queue
// Two-entry queue between the classifying front and the conversion back.
// ----------------------------------------------------------------------------
module itoa_queue #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/itoa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_back
// Extracts digits by iterative division, four quotient bits per cycle,
// buffers them and emits the text most significant character first.
// ----------------------------------------------------------------------------
module itoa_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  itoa_pkg::cmd_flags_t           cmd_flags,
    input  logic [VALUE_WIDTH-1:0]         cmd_mag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]    text_char,
    output logic                           last_char,
    output logic                           empty_result
);

    localparam int STEP_BITS = 4;
    localparam int DW        = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS     = DW / STEP_BITS;
    localparam int CW        = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW        = $clog2(VALUE_WIDTH);
    localparam int RW        = itoa_pkg::DIGIT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMPTY,
        ST_SIGN,
        ST_RD,
        ST_LOAD
    } state_t;

    state_t                         state_reg;
    itoa_pkg::cmd_flags_t           flags_reg;
    logic [DW-1:0]                  num_reg;
    logic [RW-1:0]                  rem_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [AW-1:0]                  n_reg;
    logic [itoa_pkg::DIGIT_W-1:0]   rd_data_reg;
    logic [itoa_pkg::DIGIT_W-1:0]   mem [VALUE_WIDTH];
    logic                           out_valid_reg;
    logic [itoa_pkg::CHAR_W-1:0]    text_char_reg;
    logic                           last_char_reg;
    logic                           empty_reg;

    logic [DW-1:0]                  num_next;
    logic [RW-1:0]                  rem_next;
    logic                           div_last;
    logic                           out_free;

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            rem_next = {rem_next[RW-2:0], num_next[DW-1]};
            num_next = {num_next[DW-2:0], 1'b0};
            if (rem_next >= {1'b0, flags_reg.radix})
            begin
                rem_next    = rem_next - {1'b0, flags_reg.radix};
                num_next[0] = 1'b1;
            end
        end
    end

    assign div_last  = (cnt_reg == CW'(STEPS - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_last)
        begin
            mem[n_reg] <= rem_next[itoa_pkg::DIGIT_W-1:0];
        end
        if (state_reg == ST_RD)
        begin
            rd_data_reg <= mem[n_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flags_reg     <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            text_char_reg <= '0;
            last_char_reg <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        flags_reg <= cmd_flags;
                        num_reg   <= DW'(cmd_mag);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        n_reg     <= '0;
                        state_reg <= cmd_flags.empty ? ST_EMPTY : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    num_reg <= num_next;
                    if (div_last)
                    begin
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        if (num_next == '0 || n_reg == AW'(VALUE_WIDTH - 1))
                        begin
                            state_reg <= flags_reg.neg ? ST_SIGN : ST_RD;
                        end
                        else
                        begin
                            n_reg <= n_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= itoa_pkg::NUL_CHAR;
                        last_char_reg <= 1'b1;
                        empty_reg     <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_SIGN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= itoa_pkg::MINUS_CHAR;
                        last_char_reg <= 1'b0;
                        empty_reg     <= 1'b0;
                        state_reg     <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        text_char_reg <= itoa_pkg::digit_char(rd_data_reg);
                        last_char_reg <= (n_reg == '0);
                        empty_reg     <= 1'b0;
                        if (n_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            n_reg     <= n_reg - 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign text_char    = text_char_reg;
    assign last_char    = last_char_reg;
    assign empty_result = empty_reg;

endmodule

FILE: hw/rtl/int_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_ascii_radix
// Signed integer to ASCII text in a radix from 2 to 36, one character per
// output item, most significant first.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | value
//   cfg     | cfg_valid / cfg_ready | radix
//   out     | out_valid / out_ready | text_char, last_char, empty_result
//
// Each digit passes through the divider at four quotient bits per cycle;
// on the emit side each digit is read from the digit buffer and then
// loaded into the output register, with the sign first for a negative value.
// The two-entry queue lets the next item be taken while one converts.
// Reset restores radix 10 and empties the queue and output register.
// A stalled output holds its character and halts the back end at its next emit.
// ----------------------------------------------------------------------------
module int_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [VALUE_WIDTH-1:0]  value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [itoa_pkg::RADIX_W-1:0]   radix,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]    text_char,
    output logic                           last_char,
    output logic                           empty_result
);

    localparam int FW = $bits(itoa_pkg::cmd_flags_t);
    localparam int QW = FW + VALUE_WIDTH;

    logic                       f_valid;
    logic                       f_ready;
    itoa_pkg::cmd_flags_t       f_flags;
    logic [VALUE_WIDTH-1:0]     f_mag;
    logic                       q_valid;
    logic                       q_ready;
    logic [QW-1:0]              q_data;
    itoa_pkg::cmd_flags_t       q_flags;
    logic [VALUE_WIDTH-1:0]     q_mag;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .radix     (radix),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_flags (f_flags),
        .cmd_mag   (f_mag)
    );

    itoa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_flags, f_mag}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_flags = q_data[QW-1:VALUE_WIDTH];
    assign q_mag   = q_data[VALUE_WIDTH-1:0];

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd_ready    (q_ready),
        .cmd_flags    (q_flags),
        .cmd_mag      (q_mag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .text_char    (text_char),
        .last_char    (last_char),
        .empty_result (empty_result)
    );

endmodule

FILE: hw/rtl/itoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks on the converter's output stream.
// ----------------------------------------------------------------------------
module itoa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [itoa_pkg::CHAR_W-1:0]   text_char,
    input  logic                          last_char,
    input  logic                          empty_result
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_char)
            && $stable(last_char) && $stable(empty_result))
        else $error("stalled output item changed");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_result |-> last_char && text_char == itoa_pkg::NUL_CHAR)
        else $error("empty result not a lone NUL item");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_char == itoa_pkg::MINUS_CHAR |-> !last_char && !empty_result)
        else $error("minus sign ends or empties a text");

    a_no_empty_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_char |=> !(out_valid && empty_result))
        else $error("empty result inside a text");

endmodule

bind int_to_ascii_radix itoa_checker u_itoa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .text_char    (text_char),
    .last_char    (last_char),
    .empty_result (empty_result)
);
